// ===== src/rfr_pkg.sv =====
// Shared types, constants and the CRC step function of the remote frame receiver.
package rfr_pkg;

  localparam int FRAME_BYTES = 21;
  localparam int CRC_SPAN    = 19;
  localparam int CNT_W       = 5;
  localparam int CH_W        = 11;
  localparam int TO_W        = 8;
  localparam int FRAME_W     = FRAME_BYTES * 8;

  localparam logic [CNT_W-1:0] CNT_MAX    = 5'd31;
  localparam logic [15:0]      CRC_INIT   = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY   = 16'h8408;
  localparam logic [7:0]       HDR_BYTE0  = 8'hA9;
  localparam logic [7:0]       HDR_BYTE1  = 8'h53;
  localparam logic [CH_W-1:0]  CENTER_RST = 11'd1024;
  localparam logic [TO_W-1:0]  TIMEOUT_RST = 8'd10;

  typedef enum logic [1:0] {
    CMD_DATA = 2'd0,
    CMD_END  = 2'd1,
    CMD_TICK = 2'd2
  } rfr_cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_LEN = 3'd1,
    ST_BAD_HDR = 3'd2,
    ST_BAD_CRC = 3'd3,
    ST_OFFLINE = 3'd4
  } rfr_status_t;

  typedef enum logic [0:0] {
    CFG_CENTER  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } rfr_cfg_idx_t;

  // Result payload, laid out so that the lowest field sits in the lowest bits.
  typedef struct packed {
    logic [3:0]         pad;
    logic [15:0]        keys_clicked;
    logic [15:0]        keys_pressed;
    logic [5:0]         mouse_buttons;
    logic [47:0]        mouse_motion;
    logic [5:0]         switch_bits;
    logic signed [10:0] dial_offset;
    logic signed [10:0] stick_left_h;
    logic signed [10:0] stick_left_v;
    logic signed [10:0] stick_right_v;
    logic signed [10:0] stick_right_h;
    logic               online;
  } rfr_result_t;

  localparam int RES_W = $bits(rfr_result_t);

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/remote_frame_receiver.sv =====
// Remote control frame receiver: byte collection, CRC check, field unpacking and timeout.
//
// Usage: each input request carries a command in in_tuser and a byte in in_tdata.
// A data command stores one of the first 21 bytes of a frame; the first 19 fold into the CRC.
// A frame-end command checks length, header and CRC and always returns one result
// whose status (out_tuser) gives the verdict; a good frame also returns the unpacked
// sticks, dial, switches, mouse and keys, and marks the remote online. A timer tick
// counts the offline timer down and returns an offline result once, on the tick
// that expires it while online. Configuration writes on cfg_ set the stick center
// and the timeout and are always accepted.
// Each result is computed combinationally and registered on the out_ channel.
// Throughput: one request per cycle while in_tready is high; all work for a request
// is done in the single stage ahead of the output register.
// When the receiver stalls, a second result is parked in a skid register and
// in_tready drops only while that register is full.
// Reset: synchronous, active low; clears the byte counter, history and online flag, sets
// the CRC to FFFF, the center to 1024, and timeout and offline timer to ten ticks. The frame
// store itself is not cleared; a frame is read only after all its bytes are written.
module remote_frame_receiver
  import rfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic [1:0]        in_tuser,   // [1:0] cmd
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] online, [11:1] stick_right_h, [22:12] stick_right_v, [33:23] stick_left_v,
  // [44:34] stick_left_h, [55:45] dial_offset, [61:56] switch_bits,
  // [109:62] mouse_motion, [115:110] mouse_buttons, [131:116] keys_pressed,
  // [147:132] keys_clicked, [151:148] zero
  output logic [RES_W-1:0]  out_tdata,
  output logic [2:0]        out_tuser,  // [2:0] status
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [CH_W-1:0]   cfg_data
);

  logic [CH_W-1:0]  center_r;
  logic [TO_W-1:0]  timeout_r;
  logic [7:0]       store_r [FRAME_BYTES];
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [2:0]       prev_press_r, prev_press_nxt;
  logic [15:0]      prev_keys_r, prev_keys_nxt;
  logic             online_r, online_nxt;
  logic [TO_W-1:0]  ticks_r, ticks_nxt;

  logic             out_valid_r, out_valid_nxt;
  rfr_result_t      out_data_r, out_data_nxt;
  rfr_status_t      out_status_r, out_status_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  rfr_result_t      skid_data_r, skid_data_nxt;
  rfr_status_t      skid_status_r, skid_status_nxt;

  logic             in_acc;
  logic             out_take;
  logic             store_we;
  logic             res_valid;
  rfr_result_t      res_data;
  rfr_status_t      res_status;
  logic [FRAME_W-1:0] frame_bits;
  rfr_status_t      chk_status;
  logic [2:0]       press;
  logic [15:0]      keys;
  logic [TO_W-1:0]  reload;

  assign in_tready  = ~skid_valid_r;
  assign in_acc     = in_tvalid & in_tready;
  assign out_take   = out_valid_r & out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r  <= CENTER_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (rfr_cfg_idx_t'(cfg_index))
        CFG_CENTER:  center_r  <= cfg_data;
        CFG_TIMEOUT: timeout_r <= cfg_data[TO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_bits[i*8 +: 8] = store_r[i];
    end
  end

  assign press  = {frame_bits[132], frame_bits[130], frame_bits[128]};
  assign keys   = frame_bits[136 +: 16];
  assign reload = (timeout_r == '0) ? TO_W'(1) : timeout_r;

  always_comb begin
    if (byte_count_r != CNT_W'(FRAME_BYTES)) begin
      chk_status = ST_BAD_LEN;
    end else if (store_r[0] != HDR_BYTE0 || store_r[1] != HDR_BYTE1) begin
      chk_status = ST_BAD_HDR;
    end else if ({store_r[20], store_r[19]} != crc_r) begin
      chk_status = ST_BAD_CRC;
    end else begin
      chk_status = ST_OK;
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    prev_press_nxt = prev_press_r;
    prev_keys_nxt  = prev_keys_r;
    online_nxt     = online_r;
    ticks_nxt      = ticks_r;
    store_we       = 1'b0;
    res_valid      = 1'b0;
    res_status     = ST_OK;
    res_data       = '0;
    if (in_acc) begin
      case (rfr_cmd_t'(in_tuser))
        CMD_DATA: begin
          if (byte_count_r < CNT_W'(FRAME_BYTES)) begin
            store_we = 1'b1;
            if (byte_count_r < CNT_W'(CRC_SPAN)) begin
              crc_nxt = crc_byte(crc_r, in_tdata);
            end
          end
          if (byte_count_r != CNT_MAX) begin
            byte_count_nxt = byte_count_r + CNT_W'(1);
          end
        end
        CMD_END: begin
          res_valid      = 1'b1;
          res_status     = chk_status;
          byte_count_nxt = '0;
          crc_nxt        = CRC_INIT;
          if (chk_status == ST_OK) begin
            online_nxt     = 1'b1;
            ticks_nxt      = reload;
            prev_press_nxt = press;
            prev_keys_nxt  = keys;
            res_data.stick_right_h = signed'(frame_bits[16 +: CH_W] - center_r);
            res_data.stick_right_v = signed'(frame_bits[27 +: CH_W] - center_r);
            res_data.stick_left_v  = signed'(frame_bits[38 +: CH_W] - center_r);
            res_data.stick_left_h  = signed'(frame_bits[49 +: CH_W] - center_r);
            res_data.dial_offset   = signed'(frame_bits[65 +: CH_W] - center_r);
            res_data.switch_bits   = {frame_bits[76], frame_bits[64], frame_bits[63],
                                      frame_bits[62], frame_bits[61:60]};
            res_data.mouse_motion  = frame_bits[80 +: 48];
            res_data.mouse_buttons = {press & ~prev_press_r, press};
            res_data.keys_pressed  = keys;
            res_data.keys_clicked  = keys & ~prev_keys_r;
          end
          res_data.online = online_nxt;
        end
        CMD_TICK: begin
          if (ticks_r != '0) begin
            ticks_nxt = ticks_r - TO_W'(1);
            if (ticks_r == TO_W'(1) && online_r) begin
              online_nxt = 1'b0;
              res_valid  = 1'b1;
              res_status = ST_OFFLINE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register with one skid entry; a new result only arrives while the skid is empty.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    out_status_nxt  = out_status_r;
    skid_valid_nxt  = skid_valid_r;
    skid_data_nxt   = skid_data_r;
    skid_status_nxt = skid_status_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        out_status_nxt = skid_status_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = res_data;
        out_status_nxt = res_status;
      end else begin
        skid_valid_nxt  = 1'b1;
        skid_data_nxt   = res_data;
        skid_status_nxt = res_status;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      crc_r        <= CRC_INIT;
      prev_press_r <= '0;
      prev_keys_r  <= '0;
      online_r     <= 1'b0;
      ticks_r      <= TIMEOUT_RST;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      prev_press_r <= prev_press_nxt;
      prev_keys_r  <= prev_keys_nxt;
      online_r     <= online_nxt;
      ticks_r      <= ticks_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r    <= out_data_nxt;
    out_status_r  <= out_status_nxt;
    skid_data_r   <= skid_data_nxt;
    skid_status_r <= skid_status_nxt;
    if (store_we) begin
      store_r[byte_count_r] <= in_tdata;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == CMD_END) |=> (byte_count_r == '0 && crc_r == CRC_INIT))
    else $error("frame end did not restart byte collection");

  a_online_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
    online_r |-> ticks_r != '0)
    else $error("online with an expired timer");

  a_offline_reports_offline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OFFLINE) |-> !out_data_r.online)
    else $error("offline result reports online");

  a_failed_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_tdata[RES_W-1:1] == '0)
    else $error("failed result carries payload");

endmodule
